[hdl/mesh_vertex_normal_accumulator_core_defines.svh]
// ----------------------------------------------------------------------------
// mesh vertex normal accumulator assertion macros
// concurrent checks on clock, disabled during reset; empty under SYNTH
// ----------------------------------------------------------------------------
`ifndef MESH_VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`define MESH_VERTEX_NORMAL_ACCUMULATOR_CORE_DEFINES_SVH
`ifndef SYNTH
`define MVNA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("mvna assertion failed");
`define MVNA_NEVER(lbl, expr) \
   `MVNA_ASSERT(lbl, !(expr))
`else
`define MVNA_ASSERT(lbl, prop)
`define MVNA_NEVER(lbl, expr)
`endif
`endif

[hdl/mvna_pkg.sv]
// ----------------------------------------------------------------------------
// mvna_pkg
// shared types and constants of the vertex normal accumulator
// ----------------------------------------------------------------------------
package mvna_pkg;

   localparam int VERTICES = 1024;
   localparam int ADDR_W   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
   localparam int ACC_W    = 48;
   localparam int C_W      = 43;
   localparam int DIV_NW   = 64;
   localparam int DIV_DW   = 33;

   localparam logic [1:0] CMD_ACC   = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [9:0]         vertex_a;
      logic [9:0]         vertex_b;
      logic signed [31:0] face_a_x;
      logic signed [31:0] face_a_y;
      logic signed [31:0] face_a_z;
      logic signed [31:0] face_b_x;
      logic signed [31:0] face_b_y;
      logic signed [31:0] face_b_z;
      logic [31:0]        area_a;
      logic [31:0]        area_b;
      logic [31:0]        edge_length;
   } req_type;

   typedef struct packed {
      logic [9:0]         vertex_index;
      logic signed [31:0] normal_x;
      logic signed [31:0] normal_y;
      logic signed [31:0] normal_z;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic [DIV_NW-1:0]  num;
      logic [DIV_DW-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic [DIV_NW-1:0]  quo;
   } div_rsp_type;

   typedef logic [2:0][ACC_W-1:0] acc_type;

endpackage

[hdl/mvna_div.sv]
// ----------------------------------------------------------------------------
// mvna_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mvna_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mvna_pkg::div_req_type req,
   output mvna_pkg::div_rsp_type rsp
);

   localparam int NW  = mvna_pkg::DIV_NW;
   localparam int DW  = mvna_pkg::DIV_DW;
   localparam int CNT_W = $clog2(NW);

   logic [NW-1:0]    num_ff, num_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DW:0]      shifted;
   logic [DW:0]      trial;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, num_ff[NW-1]};
      trial   = shifted - {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         num_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DW]) begin
            rem_in = trial[DW-1:0];
            num_in = {num_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            num_in = {num_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quo  = num_ff;

endmodule

[hdl/mesh_vertex_normal_accumulator_core.sv]
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator_core
// edge weighted vertex normal accumulation with per vertex readback
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. Command 0 adds
// an edge's blended, length weighted normal to both endpoint accumulators,
// command 1 returns the unit normal of one vertex, command 2 zeroes one
// vertex. Only a read returns a beat: rsp_valid is high for one cycle with
// rsp_data; the receiver cannot stall and must take it then.
// All divisions go through one shared radix-2 divider, the squares and
// products through one 32x32 multiplier, the square root through a
// two-bits-a-step loop. An edge takes up to eleven divisions; a read takes
// up to three divisions, a normalizing shift and a square root. A clear or
// a skipped edge is taken while idle and busy does not rise; busy stays
// high for the whole of an edge or a read.
// After reset the accumulator store is swept to zero, one entry a cycle,
// over all VERTICES entries; busy is high during the sweep.
// ----------------------------------------------------------------------------
`include "mesh_vertex_normal_accumulator_core_defines.svh"

module mesh_vertex_normal_accumulator_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mvna_pkg::req_type req_data,
   output logic              rsp_valid,
   output mvna_pkg::rsp_type rsp_data
);

   localparam int AW    = mvna_pkg::ADDR_W;
   localparam int ACC_W = mvna_pkg::ACC_W;
   localparam int C_W   = mvna_pkg::C_W;

   localparam logic [4:0] S_CLR  = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_WA   = 5'd2;
   localparam logic [4:0] S_WB   = 5'd3;
   localparam logic [4:0] S_UA   = 5'd4;
   localparam logic [4:0] S_UB   = 5'd5;
   localparam logic [4:0] S_MA   = 5'd6;
   localparam logic [4:0] S_AA   = 5'd7;
   localparam logic [4:0] S_MB   = 5'd8;
   localparam logic [4:0] S_AB   = 5'd9;
   localparam logic [4:0] S_CD   = 5'd10;
   localparam logic [4:0] S_RD   = 5'd11;
   localparam logic [4:0] S_RW   = 5'd12;
   localparam logic [4:0] S_NMAX = 5'd13;
   localparam logic [4:0] S_NORM = 5'd14;
   localparam logic [4:0] S_SQM  = 5'd15;
   localparam logic [4:0] S_SQA  = 5'd16;
   localparam logic [4:0] S_SQRT = 5'd17;
   localparam logic [4:0] S_OD   = 5'd18;
   localparam logic [4:0] S_EMIT = 5'd19;

   // magnitude helpers
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      mag32 = v[31] ? 32'(-v) : 32'(v);
   endfunction

   function automatic logic [ACC_W-1:0] mag48(input logic signed [ACC_W-1:0] v);
      mag48 = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
   endfunction

   function automatic logic signed [31:0] unit_sat(input logic [63:0] q,
                                                   input logic neg);
      logic [63:0] c;
      c = q;
      if (neg) begin
         if (q > 64'h8000_0000) c = 64'h8000_0000;
         unit_sat = 32'(-c);
      end else begin
         if (q > 64'h7FFF_FFFF) c = 64'h7FFF_FFFF;
         unit_sat = c[31:0];
      end
   endfunction

   function automatic logic [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                input logic signed [C_W-1:0] c);
      logic signed [ACC_W:0] s;
      s = (ACC_W+1)'(a) + (ACC_W+1)'(c);
      if (s[ACC_W:ACC_W-1] == 2'b01)      sat_add = {1'b0, {(ACC_W-1){1'b1}}};
      else if (s[ACC_W:ACC_W-1] == 2'b10) sat_add = {1'b1, {(ACC_W-1){1'b0}}};
      else                                sat_add = s[ACC_W-1:0];
   endfunction

   function automatic logic idx_ok(input logic [9:0] v);
      idx_ok = (32'(v) < mvna_pkg::VERTICES);
   endfunction

   logic [4:0]           state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 wait_ff, wait_in;
   logic [1:0]           k_ff, k_in;
   logic                 ep_ff, ep_in;
   logic                 read_ff, read_in;
   logic [9:0]           va_ff, va_in, vb_ff, vb_in;
   logic signed [31:0]   fa_ff [3], fa_in [3];
   logic signed [31:0]   fb_ff [3], fb_in [3];
   logic [31:0]          aa_ff, aa_in, ab_ff, ab_in, len_ff, len_in;
   logic [31:0]          wa_ff, wa_in, wb_ff, wb_in;
   logic signed [31:0]   ua_ff, ua_in, ub_ff, ub_in;
   logic [63:0]          prod_ff, prod_in;
   logic                 psign_ff, psign_in;
   logic signed [63:0]   n_ff, n_in;
   logic signed [C_W-1:0] c_ff [3], c_in [3];
   logic [ACC_W-1:0]     s_ff [3], s_in [3];
   logic                 neg_ff [3], neg_in [3];
   logic [ACC_W-1:0]     m_ff, m_in;
   logic [63:0]          ssq_ff, ssq_in;
   logic [63:0]          sv_ff, sv_in, res_ff, res_in, bit_ff, bit_in;
   logic signed [31:0]   ov_ff [3], ov_in [3];
   logic                 stat_ff, stat_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mvna_pkg::rsp_type    rsp_ff, rsp_in;

   mvna_pkg::div_req_type div_req;
   mvna_pkg::div_rsp_type div_rsp;

   logic [31:0]          mul_x, mul_y;
   logic [63:0]          mul_p;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa, mem_ra;
   mvna_pkg::acc_type    mem_wd;
   mvna_pkg::acc_type    mem [mvna_pkg::VERTICES];
   mvna_pkg::acc_type    rdata_ff;

   logic [32:0]          area_sum;
   logic [63:0]          n_mag;
   logic [63:0]          sq_step;
   logic [ACC_W-1:0]     max_s;
   logic [9:0]           cur_v;

   mvna_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // shared multiplier
   assign mul_p = 64'(mul_x) * 64'(mul_y);

   // accumulator store
   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rdata_ff <= mem[mem_ra];
   end

   // sequencer
   always_comb begin
      state_in = state_ff;  clr_in = clr_ff;   wait_in = wait_ff;
      k_in = k_ff;          ep_in = ep_ff;     read_in = read_ff;
      va_in = va_ff;        vb_in = vb_ff;     fa_in = fa_ff;   fb_in = fb_ff;
      aa_in = aa_ff;        ab_in = ab_ff;     len_in = len_ff;
      wa_in = wa_ff;        wb_in = wb_ff;     ua_in = ua_ff;   ub_in = ub_ff;
      prod_in = prod_ff;    psign_in = psign_ff; n_in = n_ff;   c_in = c_ff;
      s_in = s_ff;          neg_in = neg_ff;   m_in = m_ff;     ssq_in = ssq_ff;
      sv_in = sv_ff;        res_in = res_ff;   bit_in = bit_ff;
      ov_in = ov_ff;        stat_in = stat_ff;
      rsp_valid_in = 1'b0;  rsp_in = rsp_ff;
      div_req = '0;
      mul_x = '0;           mul_y = '0;
      mem_we = 1'b0;        mem_wa = clr_ff;   mem_wd = '0;
      cur_v = ep_ff ? vb_ff : va_ff;
      mem_ra = AW'(cur_v);
      area_sum = {1'b0, aa_ff} + {1'b0, ab_ff};
      n_mag = n_ff[63] ? 64'(-n_ff) : 64'(n_ff);
      sq_step = res_ff + bit_ff;
      max_s = s_ff[0];
      if (s_ff[1] > max_s) max_s = s_ff[1];
      if (s_ff[2] > max_s) max_s = s_ff[2];

      case (state_ff)
         // zero sweep after reset
         S_CLR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(mvna_pkg::VERTICES - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               va_in  = req_data.vertex_a;
               vb_in  = req_data.vertex_b;
               fa_in[0] = req_data.face_a_x;
               fa_in[1] = req_data.face_a_y;
               fa_in[2] = req_data.face_a_z;
               fb_in[0] = req_data.face_b_x;
               fb_in[1] = req_data.face_b_y;
               fb_in[2] = req_data.face_b_z;
               aa_in  = req_data.area_a;
               ab_in  = req_data.area_b;
               len_in = req_data.edge_length;
               k_in   = 2'd0;
               ep_in  = 1'b0;
               wait_in = 1'b0;
               case (req_data.command)
                  mvna_pkg::CMD_ACC: begin
                     read_in = 1'b0;
                     if ((req_data.area_a != '0 || req_data.area_b != '0) &&
                         req_data.edge_length != '0)
                        state_in = S_WA;
                  end
                  mvna_pkg::CMD_READ: begin
                     read_in  = 1'b1;
                     state_in = S_RD;
                  end
                  mvna_pkg::CMD_CLEAR: begin
                     mem_we = idx_ok(req_data.vertex_a);
                     mem_wa = AW'(req_data.vertex_a);
                  end
                  default: ;
               endcase
            end
         end
         // blend weights
         S_WA, S_WB: begin
            div_req.den = area_sum;
            div_req.num = (state_ff == S_WA) ? {1'b0, ab_ff, 31'b0} : {1'b0, aa_ff, 31'b0};
            if (!wait_ff) begin
               div_req.start = 1'b1;
               wait_in = 1'b1;
            end else if (div_rsp.done) begin
               wait_in = 1'b0;
               if (state_ff == S_WA) begin
                  wa_in = div_rsp.quo[31:0];
                  state_in = S_WB;
               end else begin
                  wb_in = div_rsp.quo[31:0];
                  state_in = S_UA;
               end
            end
         end
         // unit face normal component
         S_UA, S_UB: begin
            if (state_ff == S_UA) begin
               div_req.den = {1'b0, aa_ff};
               div_req.num = {2'b0, mag32(fa_ff[k_ff]), 30'b0};
            end else begin
               div_req.den = {1'b0, ab_ff};
               div_req.num = {2'b0, mag32(fb_ff[k_ff]), 30'b0};
            end
            if (div_req.den == '0) begin
               if (state_ff == S_UA) begin
                  ua_in = '0;
                  state_in = S_UB;
               end else begin
                  ub_in = '0;
                  state_in = S_MA;
               end
            end else if (!wait_ff) begin
               div_req.start = 1'b1;
               wait_in = 1'b1;
            end else if (div_rsp.done) begin
               wait_in = 1'b0;
               if (state_ff == S_UA) begin
                  ua_in = unit_sat(div_rsp.quo, fa_ff[k_ff][31]);
                  state_in = S_UB;
               end else begin
                  ub_in = unit_sat(div_rsp.quo, fb_ff[k_ff][31]);
                  state_in = S_MA;
               end
            end
         end
         // weighted sum of unit normals
         S_MA: begin
            mul_x = mag32(ua_ff);
            mul_y = wa_ff;
            prod_in = mul_p;
            psign_in = ua_ff[31];
            state_in = S_AA;
         end
         S_AA: begin
            n_in = psign_ff ? -$signed(prod_ff) : $signed(prod_ff);
            state_in = S_MB;
         end
         S_MB: begin
            mul_x = mag32(ub_ff);
            mul_y = wb_ff;
            prod_in = mul_p;
            psign_in = ub_ff[31];
            state_in = S_AB;
         end
         S_AB: begin
            n_in = psign_ff ? n_ff - $signed(prod_ff) : n_ff + $signed(prod_ff);
            state_in = S_CD;
         end
         // divide by edge length
         S_CD: begin
            div_req.den = {1'b0, len_ff};
            div_req.num = n_mag;
            if (!wait_ff) begin
               div_req.start = 1'b1;
               wait_in = 1'b1;
            end else if (div_rsp.done) begin
               wait_in = 1'b0;
               c_in[k_ff] = n_ff[63] ? -$signed(div_rsp.quo[63:21])
                                     : $signed(div_rsp.quo[63:21]);
               if (k_ff == 2'd2) begin
                  ep_in = 1'b0;
                  state_in = S_RD;
               end else begin
                  k_in = k_ff + 2'd1;
                  state_in = S_UA;
               end
            end
         end
         // store read
         S_RD: begin
            if (idx_ok(cur_v)) begin
               state_in = S_RW;
            end else if (read_ff) begin
               ov_in[0] = '0; ov_in[1] = '0; ov_in[2] = '0;
               stat_in = 1'b1;
               state_in = S_EMIT;
            end else if (!ep_ff) begin
               ep_in = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_RW: begin
            if (read_ff) begin
               for (int i = 0; i < 3; i++) begin
                  s_in[i]   = mag48(rdata_ff[i]);
                  neg_in[i] = rdata_ff[i][ACC_W-1];
               end
               state_in = S_NMAX;
            end else begin
               mem_we = 1'b1;
               mem_wa = AW'(cur_v);
               for (int i = 0; i < 3; i++)
                  mem_wd[i] = sat_add($signed(rdata_ff[i]), c_ff[i]);
               if (!ep_ff) begin
                  ep_in = 1'b1;
                  state_in = S_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         // normalize the largest magnitude into [2^29, 2^30)
         S_NMAX: begin
            m_in = max_s;
            if (max_s == '0) begin
               ov_in[0] = '0; ov_in[1] = '0; ov_in[2] = '0;
               stat_in = 1'b1;
               state_in = S_EMIT;
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (m_ff[ACC_W-1:30] != '0) begin
               for (int i = 0; i < 3; i++) s_in[i] = s_ff[i] >> 1;
               m_in = m_ff >> 1;
            end else if (!m_ff[29]) begin
               for (int i = 0; i < 3; i++) s_in[i] = s_ff[i] << 1;
               m_in = m_ff << 1;
            end else begin
               k_in = 2'd0;
               ssq_in = '0;
               state_in = S_SQM;
            end
         end
         // sum of squares
         S_SQM: begin
            mul_x = s_ff[k_ff][31:0];
            mul_y = s_ff[k_ff][31:0];
            prod_in = mul_p;
            state_in = S_SQA;
         end
         S_SQA: begin
            ssq_in = ssq_ff + prod_ff;
            if (k_ff == 2'd2) begin
               sv_in  = ssq_ff + prod_ff;
               res_in = '0;
               bit_in = 64'd1 << 62;
               state_in = S_SQRT;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = S_SQM;
            end
         end
         // integer square root
         S_SQRT: begin
            if (sv_ff >= sq_step) begin
               sv_in  = sv_ff - sq_step;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               k_in = 2'd0;
               stat_in = 1'b0;
               state_in = S_OD;
            end
         end
         // output components
         S_OD: begin
            div_req.den = res_ff[32:0];
            div_req.num = {4'b0, s_ff[k_ff][29:0], 30'b0};
            if (!wait_ff) begin
               div_req.start = 1'b1;
               wait_in = 1'b1;
            end else if (div_rsp.done) begin
               wait_in = 1'b0;
               ov_in[k_ff] = neg_ff[k_ff] ? 32'(-div_rsp.quo[31:0]) : div_rsp.quo[31:0];
               if (k_ff == 2'd2) state_in = S_EMIT;
               else k_in = k_ff + 2'd1;
            end
         end
         S_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_in.vertex_index = va_ff;
            rsp_in.normal_x = ov_ff[0];
            rsp_in.normal_y = ov_ff[1];
            rsp_in.normal_z = ov_ff[2];
            rsp_in.status = stat_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         wait_ff      <= 1'b0;
         k_ff         <= '0;
         ep_ff        <= 1'b0;
         read_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         wait_ff      <= wait_in;
         k_ff         <= k_in;
         ep_ff        <= ep_in;
         read_ff      <= read_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      va_ff <= va_in;     vb_ff <= vb_in;
      fa_ff <= fa_in;     fb_ff <= fb_in;
      aa_ff <= aa_in;     ab_ff <= ab_in;     len_ff <= len_in;
      wa_ff <= wa_in;     wb_ff <= wb_in;
      ua_ff <= ua_in;     ub_ff <= ub_in;
      prod_ff <= prod_in; psign_ff <= psign_in;
      n_ff <= n_in;       c_ff <= c_in;
      s_ff <= s_in;       neg_ff <= neg_in;   m_ff <= m_in;
      ssq_ff <= ssq_in;
      sv_ff <= sv_in;     res_ff <= res_in;   bit_ff <= bit_in;
      ov_ff <= ov_in;     stat_ff <= stat_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `MVNA_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid)
   `MVNA_ASSERT(a_rsp_idle, rsp_valid |-> !busy)
   `MVNA_NEVER(a_div_overlap, div_req.start && div_rsp.busy)
   `MVNA_ASSERT(a_div_owned, div_rsp.done |-> wait_ff)

endmodule

[tb/sv/tb_mesh_vertex_normal_accumulator_core.sv]
// ----------------------------------------------------------------------------
// tb_mesh_vertex_normal_accumulator_core
// self-checking bench: edge, read and clear beats; read results checked against a predictor
// ----------------------------------------------------------------------------
// A queue of command beats feeds a clocked driver; a clocked monitor compares
// each read result field by field with the oldest predicted normal. The
// predictor keeps its own copy of the accumulator store and repeats the
// fixed point arithmetic of edges and reads. Random beats favor a small set
// of vertices so accumulators grow, saturate and get cleared.
// ----------------------------------------------------------------------------
module tb_mesh_vertex_normal_accumulator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ACC_HI     = 64'sd140737488355327;
   localparam longint ACC_LO     = -ACC_HI - 1;
   localparam int     CYCLE_MAX  = 8_000_000;
   localparam int     DRAIN_CYC  = 1000;
   localparam int     RAND_BEATS = 1830;
   localparam logic [1:0] CMD_NONE = 2'd3;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   mvna_pkg::req_type req_data;
   logic              rsp_valid;
   mvna_pkg::rsp_type rsp_data;

   mvna_pkg::req_type cmd_q[$];
   mvna_pkg::rsp_type normal_q[$];
   longint  acc_x[mvna_pkg::VERTICES];
   longint  acc_y[mvna_pkg::VERTICES];
   longint  acc_z[mvna_pkg::VERTICES];
   int      total_beats;
   int      sent_beats;
   int      errors;
   int      cycles;
   bit      pause_done;

   mesh_vertex_normal_accumulator_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // clock, 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic longint unsigned magnitude(input longint v);
      return (v < 0) ? longint'(64'd0 - v) : v;
   endfunction

   // face area vector to Q2.30 unit component, saturating
   function automatic longint unit_comp(input longint s, input longint unsigned area);
      longint unsigned q;
      if (area == 0) return 0;
      q = (magnitude(s) << 30) / area;
      if (s < 0) begin
         if (q > 64'h80000000) q = 64'h80000000;
         return -longint'(q);
      end
      if (q > 64'h7FFFFFFF) q = 64'h7FFFFFFF;
      return longint'(q);
   endfunction

   // blended edge normal over length, Q3.40
   function automatic longint edge_comp(input longint sa, input longint sb,
                                        input longint wa, input longint wb,
                                        input longint unsigned aa,
                                        input longint unsigned ab,
                                        input longint unsigned len);
      longint n;
      longint unsigned q;
      n = unit_comp(sa, aa) * wa + unit_comp(sb, ab) * wb;
      q = (magnitude(n) / len) >> 21;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint sat_sum(input longint a, input longint c);
      longint v;
      v = a + c;
      if (v > ACC_HI) v = ACC_HI;
      if (v < ACC_LO) v = ACC_LO;
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [31:0] out_comp(input longint v, input longint unsigned s,
                                            input longint unsigned r);
      longint unsigned q;
      q = (s << 30) / r;
      if (v < 0) q = 64'd0 - q;
      return q[31:0];
   endfunction

   // update the accumulator copy; push a predicted normal for a read
   function automatic void apply_command(input mvna_pkg::req_type c);
      longint unsigned aa, ab, len, tot, mx, my, mz, m, r;
      longint wa, wb, cx, cy, cz, x, y, z;
      int nb;
      mvna_pkg::rsp_type n;
      aa  = 64'(c.area_a);
      ab  = 64'(c.area_b);
      len = 64'(c.edge_length);
      case (c.command)
         mvna_pkg::CMD_ACC: begin
            tot = aa + ab;
            if (tot != 0 && len != 0) begin
               wa = longint'((ab << 31) / tot);
               wb = longint'((aa << 31) / tot);
               cx = edge_comp(longint'(c.face_a_x), longint'(c.face_b_x), wa, wb, aa, ab, len);
               cy = edge_comp(longint'(c.face_a_y), longint'(c.face_b_y), wa, wb, aa, ab, len);
               cz = edge_comp(longint'(c.face_a_z), longint'(c.face_b_z), wa, wb, aa, ab, len);
               acc_x[c.vertex_a] = sat_sum(acc_x[c.vertex_a], cx);
               acc_y[c.vertex_a] = sat_sum(acc_y[c.vertex_a], cy);
               acc_z[c.vertex_a] = sat_sum(acc_z[c.vertex_a], cz);
               acc_x[c.vertex_b] = sat_sum(acc_x[c.vertex_b], cx);
               acc_y[c.vertex_b] = sat_sum(acc_y[c.vertex_b], cy);
               acc_z[c.vertex_b] = sat_sum(acc_z[c.vertex_b], cz);
            end
         end
         mvna_pkg::CMD_CLEAR: begin
            acc_x[c.vertex_a] = 0;
            acc_y[c.vertex_a] = 0;
            acc_z[c.vertex_a] = 0;
         end
         mvna_pkg::CMD_READ: begin
            n = '0;
            n.vertex_index = c.vertex_a;
            n.status = 1'b1;
            x = acc_x[c.vertex_a];
            y = acc_y[c.vertex_a];
            z = acc_z[c.vertex_a];
            mx = magnitude(x);
            my = magnitude(y);
            mz = magnitude(z);
            m = mx;
            if (my > m) m = my;
            if (mz > m) m = mz;
            if (m != 0) begin
               nb = 0;
               while (nb < 64 && (m >> nb) != 0) nb++;
               if (nb > 30) begin
                  mx >>= nb - 30; my >>= nb - 30; mz >>= nb - 30;
               end else begin
                  mx <<= 30 - nb; my <<= 30 - nb; mz <<= 30 - nb;
               end
               r = int_sqrt(mx * mx + my * my + mz * mz);
               n.normal_x = out_comp(x, mx, r);
               n.normal_y = out_comp(y, my, r);
               n.normal_z = out_comp(z, mz, r);
               n.status = 1'b0;
            end
            normal_q.push_back(n);
         end
         default: ;
      endcase
   endfunction

   function automatic mvna_pkg::req_type edge_beat(input int va, input int vb,
                                         input logic [31:0] f, input logic [31:0] aa,
                                         input logic [31:0] ab, input logic [31:0] len);
      mvna_pkg::req_type c;
      c = '0;
      c.command = mvna_pkg::CMD_ACC;
      c.vertex_a = 10'(va);
      c.vertex_b = 10'(vb);
      c.face_a_x = f; c.face_a_y = -f; c.face_a_z = f >>> 1;
      c.face_b_x = f; c.face_b_y = f;  c.face_b_z = ~f;
      c.area_a = aa;
      c.area_b = ab;
      c.edge_length = len;
      return c;
   endfunction

   function automatic mvna_pkg::req_type op_beat(input logic [1:0] op, input int v);
      mvna_pkg::req_type c;
      c = '0;
      c.command = op;
      c.vertex_a = 10'(v);
      return c;
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(3))
         0: return $urandom_range(65536 * 4);
         1: return 32'h0 - $urandom_range(65536 * 4);
         default: return $urandom;
      endcase
   endfunction

   // directed beats, then random ones
   initial begin
      mvna_pkg::req_type c;
      int pick, v;
      foreach (acc_x[i]) begin
         acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
      end
      cmd_q.push_back(op_beat(mvna_pkg::CMD_READ, 0));
      cmd_q.push_back(op_beat(mvna_pkg::CMD_READ, 1023));
      cmd_q.push_back(edge_beat(1, 2, 32'h7FFFFFFF, 32'h0, 32'h0, 32'h10000));
      cmd_q.push_back(edge_beat(1, 2, 32'h80000000, 32'h10000, 32'h10000, 32'h0));
      cmd_q.push_back(edge_beat(1, 2, 32'h80000000, 32'h0, 32'h30000, 32'h10000));
      cmd_q.push_back(edge_beat(3, 3, 32'h00018000, 32'h20000, 32'h0, 32'h8000));
      cmd_q.push_back(edge_beat(1, 2, 32'h7FFFFFFF, 32'h1, 32'hFFFFFFFF, 32'h1));
      cmd_q.push_back(edge_beat(1023, 0, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                32'hFFFFFFFF));
      cmd_q.push_back(edge_beat(4, 5, 32'h00010000, 32'h10000, 32'h10000, 32'h10000));
      for (int i = 0; i < 6; i++)
         cmd_q.push_back(edge_beat(6, 6, 32'h7FFFFFFF, 32'h1, 32'h1, 32'h1));
      cmd_q.push_back(op_beat(mvna_pkg::CMD_READ, 1));
      cmd_q.push_back(op_beat(mvna_pkg::CMD_READ, 3));
      cmd_q.push_back(op_beat(mvna_pkg::CMD_READ, 6));
      cmd_q.push_back(op_beat(mvna_pkg::CMD_READ, 1023));
      cmd_q.push_back(op_beat(CMD_NONE, 1));
      cmd_q.push_back(op_beat(mvna_pkg::CMD_CLEAR, 1));
      cmd_q.push_back(op_beat(mvna_pkg::CMD_READ, 1));
      cmd_q.push_back(op_beat(mvna_pkg::CMD_READ, 2));
      for (int i = 0; i < RAND_BEATS; i++) begin
         c = '0;
         {c.face_a_x, c.face_a_y, c.face_a_z} = {rand_field(), rand_field(), rand_field()};
         {c.face_b_x, c.face_b_y, c.face_b_z} = {rand_field(), rand_field(), rand_field()};
         c.area_a = ($urandom_range(9) == 0) ? 32'h0 : rand_field();
         c.area_b = ($urandom_range(9) == 0) ? 32'h0 : rand_field();
         case ($urandom_range(7))
            0: c.edge_length = $urandom_range(16);
            1: c.edge_length = 32'h0;
            default: c.edge_length = $urandom;
         endcase
         v = ($urandom_range(4) == 0) ? $urandom_range(1023) : $urandom_range(7);
         c.vertex_a = 10'(v);
         c.vertex_b = ($urandom_range(4) == 0) ? 10'($urandom_range(1023))
                                               : 10'($urandom_range(7));
         pick = $urandom_range(99);
         if (pick < 55) c.command = mvna_pkg::CMD_ACC;
         else if (pick < 85) c.command = mvna_pkg::CMD_READ;
         else if (pick < 96) c.command = mvna_pkg::CMD_CLEAR;
         else c.command = CMD_NONE;
         cmd_q.push_back(c);
      end
      total_beats = cmd_q.size();
   end

   // reset
   initial begin
      errors = 0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // driver: one beat offered at a time, idling by phase
   always @(posedge clock) begin
      int idle_pct;
      bit hold;
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         sent_beats <= 0;
         pause_done <= 1'b0;
      end else if (!start || !busy) begin
         if (start) begin
            apply_command(req_data);
            sent_beats <= sent_beats + 1;
         end
         if (sent_beats < total_beats / 3) idle_pct = 37;
         else if (sent_beats < 2 * total_beats / 3) idle_pct = 73;
         else idle_pct = 0;
         hold = 1'b0;
         if (!pause_done && sent_beats >= total_beats / 2) begin
            if (normal_q.size() != 0 || start) hold = 1'b1;
            else pause_done <= 1'b1;
         end
         if (cmd_q.size() != 0 && !hold && $urandom_range(99) >= idle_pct) begin
            start <= 1'b1;
            req_data <= cmd_q.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: compare each result beat with the oldest predicted normal
   always @(posedge clock) begin
      mvna_pkg::rsp_type n;
      if (!reset && rsp_valid) begin
         if (normal_q.size() == 0) begin
            report("unexpected result", rsp_data.vertex_index, 0);
         end else begin
            n = normal_q.pop_front();
            if (rsp_data.vertex_index !== n.vertex_index)
               report("vertex_index", rsp_data.vertex_index, n.vertex_index);
            if (rsp_data.normal_x !== n.normal_x)
               report("normal_x", rsp_data.normal_x, n.normal_x);
            if (rsp_data.normal_y !== n.normal_y)
               report("normal_y", rsp_data.normal_y, n.normal_y);
            if (rsp_data.normal_z !== n.normal_z)
               report("normal_z", rsp_data.normal_z, n.normal_z);
            if (rsp_data.status !== n.status)
               report("status", rsp_data.status, n.status);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      if (reset) begin
         cycles <= 0;
      end else begin
         cycles <= cycles + 1;
         if (cycles > CYCLE_MAX) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // end of run
   initial begin
      @(negedge reset);
      wait (cmd_q.size() == 0 && !start);
      wait (normal_q.size() == 0);
      repeat (DRAIN_CYC) @(posedge clock);
      if (errors == 0 && normal_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
